>>> src/ksg_pkg.sv
// ----------------------------------------------------------------------------
// Koch curve segment generator package
// Shared types and constants for the generator's controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ksg_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_CURVE_ORDER     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_LENGTH     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_DIRECTION = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_X         = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_Y         = 3'd4;

    localparam logic [30:0] BASE_LENGTH_RESET = 31'd13107200;

    // Reciprocal of three scaled by two to the 33, and sqrt(3)/2 in Q0.32.
    localparam logic [31:0] DIV3_RECIP     = 32'hAAAA_AAAB;
    localparam logic [31:0] ROOT3_HALF_Q32 = 32'hDDB3_D743;
    localparam logic [63:0] ROUND_HALF_Q32 = 64'h0000_0000_8000_0000;

    localparam logic [2:0] DIR_COUNT = 3'd6;

    typedef struct packed {
        logic start_curve;
        logic div_step;
        logic root_step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic started;
        logic div_done;
    } t_status;

endpackage

`default_nettype wire

>>> src/ksg_if.sv
// ----------------------------------------------------------------------------
// Koch curve segment generator channels
// Request channel carrying the restart flag and segment result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface ksg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface ksg_seg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seg_x0;
    logic signed [31:0] seg_y0;
    logic signed [31:0] seg_x1;
    logic signed [31:0] seg_y1;
    logic        [2:0]  heading;
    logic               last_segment;

    modport source (output valid, output seg_x0, output seg_y0, output seg_x1,
                    output seg_y1, output heading, output last_segment,
                    input ready);
    modport sink   (input valid, input seg_x0, input seg_y0, input seg_x1,
                    input seg_y1, input heading, input last_segment,
                    output ready);
endinterface

`default_nettype wire

>>> src/koch_curve_segment_generator.sv
// ----------------------------------------------------------------------------
// Koch curve segment generator
// Emits the segments of a Koch curve of a configured order, one per request.
//
//   Channel   Direction  Handshake             Payload
//   i_req     in         valid / ready         restart
//   o_seg     out        valid / ready         seg_x0..seg_y1, heading, last
//   cfg       in         valid / ready (high)  index, data
//
// A request that continues the current curve gives its segment in the cycle
// after, and while results are taken the next request may follow at once,
// so one segment per cycle. A request that starts a curve runs the shared
// divide-by-three step once per order, then one root-three scaling.
// Reset is synchronous; the first request after reset starts a curve.
// A stalled result holds in the output register; requests wait until it moves.
// ----------------------------------------------------------------------------
`default_nettype none

module koch_curve_segment_generator #(
    parameter int MAX_ORDER   = 8,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    ksg_req_if.sink                              i_req,
    ksg_seg_if.source                            o_seg,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ksg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [ksg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ksg_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    ksg_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .i_req_restart (i_req.restart),
        .o_req_ready   (i_req.ready),
        .i_seg_ready   (o_seg.ready),
        .o_seg_valid   (o_seg.valid),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    ksg_datapath #(
        .MAX_ORDER   (MAX_ORDER),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_write    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_seg_x0       (o_seg.seg_x0),
        .o_seg_y0       (o_seg.seg_y0),
        .o_seg_x1       (o_seg.seg_x1),
        .o_seg_y1       (o_seg.seg_y1),
        .o_heading      (o_seg.heading),
        .o_last_segment (o_seg.last_segment)
    );

endmodule

`default_nettype wire

>>> src/ksg_ctrl.sv
// ----------------------------------------------------------------------------
// Koch curve segment generator controller
// Sequences curve starts, length scaling and segment emission.
// ----------------------------------------------------------------------------
`default_nettype none

module ksg_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_req_valid,
    input  wire logic            i_req_restart,
    output logic                 o_req_ready,
    input  wire logic            i_seg_ready,
    output logic                 o_seg_valid,
    input  wire ksg_pkg::t_status i_status,
    output ksg_pkg::t_cmd        o_cmd
);
    import ksg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_ROOT,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_seg_valid;
    logic   w_accept;
    logic   w_need_start;

    assign o_req_ready  = (r_state == S_IDLE) && (!r_seg_valid || i_seg_ready);
    assign w_accept     = i_req_valid && o_req_ready;
    assign w_need_start = i_req_restart || !i_status.started;
    assign o_seg_valid  = r_seg_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_need_start) begin
                        o_cmd.start_curve = 1'b1;
                        n_state           = S_DIV;
                    end else begin
                        o_cmd.emit = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_ROOT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seg_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.emit) begin
                r_seg_valid <= 1'b1;
            end else if (i_seg_ready) begin
                r_seg_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/ksg_datapath.sv
// ----------------------------------------------------------------------------
// Koch curve segment generator datapath
// Configuration registers, length scaling, heading tracking and pen update.
// ----------------------------------------------------------------------------
`default_nettype none

module ksg_datapath #(
    parameter int MAX_ORDER   = 8,
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_write,
    input  wire logic [ksg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [ksg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire ksg_pkg::t_cmd                   i_cmd,
    output ksg_pkg::t_status                     o_status,
    output logic signed [31:0]                   o_seg_x0,
    output logic signed [31:0]                   o_seg_y0,
    output logic signed [31:0]                   o_seg_x1,
    output logic signed [31:0]                   o_seg_y1,
    output logic        [2:0]                    o_heading,
    output logic                                 o_last_segment
);
    import ksg_pkg::*;

    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int IW = 2 * MAX_ORDER;
    localparam int CW = COORD_WIDTH;

    logic        [3:0]    r_cfg_order;
    logic        [30:0]   r_cfg_base;
    logic        [2:0]    r_cfg_dir;
    logic signed [31:0]   r_cfg_x;
    logic signed [31:0]   r_cfg_y;

    logic        [OW-1:0] r_run_order;
    logic        [OW-1:0] r_div_cnt;
    logic        [2:0]    r_dir;
    logic signed [CW-1:0] r_pen_x;
    logic signed [CW-1:0] r_pen_y;
    logic        [IW-1:0] r_index;
    logic        [30:0]   r_step;
    logic        [30:0]   r_step_h;
    logic                 r_started;

    logic        [OW-1:0] w_sat_order;
    logic        [2:0]    w_start_dir;
    logic signed [63:0]   w_start_x64;
    logic signed [63:0]   w_start_y64;
    logic        [63:0]   w_div_prod;
    logic        [63:0]   w_root_prod;
    logic        [31:0]   w_half_sum;
    logic        [63:0]   w_full64;
    logic        [63:0]   w_half64;
    logic        [63:0]   w_h64;
    logic        [CW-1:0] w_full;
    logic        [CW-1:0] w_half;
    logic        [CW-1:0] w_h;
    logic        [CW-1:0] w_dx;
    logic        [CW-1:0] w_dy;
    logic signed [CW-1:0] w_next_x;
    logic signed [CW-1:0] w_next_y;
    logic        [IW:0]   w_index_inc;
    logic        [IW:0]   w_total;
    logic                 w_last;
    logic        [1:0]    w_digit;
    logic        [3:0]    w_dir_sum;
    logic        [2:0]    w_next_dir;

    function automatic logic signed [31:0] from_coord(input logic signed [CW-1:0] v);
        logic signed [63:0] e;
        e = 64'(v);
        return e[31:0];
    endfunction

    assign w_sat_order = (32'(r_cfg_order) > MAX_ORDER) ? OW'(MAX_ORDER)
                                                        : OW'(r_cfg_order);
    assign w_start_dir = (r_cfg_dir >= DIR_COUNT) ? (r_cfg_dir - DIR_COUNT) : r_cfg_dir;
    assign w_start_x64 = 64'(r_cfg_x);
    assign w_start_y64 = 64'(r_cfg_y);

    assign w_div_prod  = 64'(r_step) * 64'(DIV3_RECIP);
    assign w_root_prod = 64'(r_step) * 64'(ROOT3_HALF_Q32) + ROUND_HALF_Q32;

    assign w_half_sum = 32'(r_step) + 32'd1;
    assign w_full64   = 64'(r_step);
    assign w_half64   = 64'(w_half_sum[31:1]);
    assign w_h64      = 64'(r_step_h);
    assign w_full     = w_full64[CW-1:0];
    assign w_half     = w_half64[CW-1:0];
    assign w_h        = w_h64[CW-1:0];

    always_comb begin
        w_dx = w_half;
        w_dy = '0;
        unique case (r_dir)
            3'd0: begin
                w_dx = w_full;
                w_dy = '0;
            end
            3'd1: begin
                w_dx = w_half;
                w_dy = w_h;
            end
            3'd2: begin
                w_dx = -w_half;
                w_dy = w_h;
            end
            3'd3: begin
                w_dx = -w_full;
                w_dy = '0;
            end
            3'd4: begin
                w_dx = -w_half;
                w_dy = -w_h;
            end
            default: begin
                w_dx = w_half;
                w_dy = -w_h;
            end
        endcase
    end

    assign w_next_x = r_pen_x + w_dx;
    assign w_next_y = r_pen_y + w_dy;

    assign w_index_inc = {1'b0, r_index} + (IW + 1)'(1);
    assign w_total     = (IW + 1)'(1) << {r_run_order, 1'b0};
    assign w_last      = (w_index_inc >= w_total);

    // The lowest digit that is not three is the one that carries in the
    // increment: a zero or a two there turns the heading by one step, a one
    // turns it back by two.
    always_comb begin
        w_digit = 2'd0;
        for (int i = MAX_ORDER - 1; i >= 0; i--) begin
            if (r_index[2*i +: 2] != 2'd3) begin
                w_digit = r_index[2*i +: 2];
            end
        end
    end

    assign w_dir_sum  = {1'b0, r_dir} + ((w_digit == 2'd1) ? 4'd4 : 4'd1);
    assign w_next_dir = (w_dir_sum >= {1'b0, DIR_COUNT}) ? 3'(w_dir_sum - {1'b0, DIR_COUNT})
                                                          : w_dir_sum[2:0];

    assign o_status.started  = r_started;
    assign o_status.div_done = (r_div_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_order <= '0;
            r_cfg_base  <= BASE_LENGTH_RESET;
            r_cfg_dir   <= '0;
            r_cfg_x     <= '0;
            r_cfg_y     <= '0;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_CURVE_ORDER:     r_cfg_order <= i_cfg_data[3:0];
                CFG_BASE_LENGTH:     r_cfg_base  <= i_cfg_data[30:0];
                CFG_START_DIRECTION: r_cfg_dir   <= i_cfg_data[2:0];
                CFG_START_X:         r_cfg_x     <= i_cfg_data;
                CFG_START_Y:         r_cfg_y     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_order <= '0;
            r_div_cnt   <= '0;
            r_dir       <= '0;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_index     <= '0;
            r_step      <= '0;
            r_step_h    <= '0;
            r_started   <= 1'b0;
        end else begin
            if (i_cmd.start_curve) begin
                r_run_order <= w_sat_order;
                r_div_cnt   <= w_sat_order;
                r_dir       <= w_start_dir;
                r_pen_x     <= w_start_x64[CW-1:0];
                r_pen_y     <= w_start_y64[CW-1:0];
                r_index     <= '0;
                r_step      <= r_cfg_base;
                r_started   <= 1'b1;
            end
            if (i_cmd.div_step) begin
                r_step    <= w_div_prod[63:33];
                r_div_cnt <= r_div_cnt - OW'(1);
            end
            if (i_cmd.root_step) begin
                r_step_h <= w_root_prod[62:32];
            end
            if (i_cmd.emit) begin
                r_pen_x <= w_next_x;
                r_pen_y <= w_next_y;
                r_dir   <= w_next_dir;
                if (w_last) begin
                    r_index   <= '0;
                    r_started <= 1'b0;
                end else begin
                    r_index <= w_index_inc[IW-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_seg_x0       <= from_coord(r_pen_x);
            o_seg_y0       <= from_coord(r_pen_y);
            o_seg_x1       <= from_coord(w_next_x);
            o_seg_y1       <= from_coord(w_next_y);
            o_heading      <= r_dir;
            o_last_segment <= w_last;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Koch curve segment generator testbench
// Requests are driven on falling edges with random gaps, and results are
// taken with random stalls. Every request transfer is run through a
// behavioural model of the curve walk, and each result transfer is compared
// field by field with the oldest expected segment. A short table of directed
// rows comes first, followed by random configurations and request streams.
// ----------------------------------------------------------------------------
module tb;
    import ksg_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 16;
    localparam int ORDER_CAP    = 8;
    localparam int TABLE_ROWS   = 33;

    localparam logic [63:0] SQRT3_OVER_2 = 64'd3719550787;
    localparam logic [63:0] ROUND_UP     = 64'h0000_0000_8000_0000;
    localparam logic [30:0] LENGTH_AFTER_RESET = 31'd13107200;

    localparam logic [1:0] DIGIT_LEFT  = 2'd1;
    localparam logic [1:0] DIGIT_RIGHT = 2'd2;

    localparam logic [2:0] HEAD_E  = 3'd0;
    localparam logic [2:0] HEAD_NE = 3'd1;
    localparam logic [2:0] HEAD_NW = 3'd2;
    localparam logic [2:0] HEAD_W  = 3'd3;
    localparam logic [2:0] HEAD_SW = 3'd4;
    localparam logic [2:0] HEAD_SE = 3'd5;

    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic        [2:0]  heading;
        logic               last;
    } t_segment;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
        logic                   restart;
        logic                   typed;
        t_segment               seg;
    } t_stim_row;

    localparam t_segment NO_SEG    = '0;
    localparam t_segment FIRST_SEG = '{32'sd0, 32'sd0, 32'sd13107200, 32'sd0, HEAD_E, 1'b1};

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    ksg_req_if req_ch ();
    ksg_seg_if seg_ch ();

    koch_curve_segment_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_seg       (seg_ch),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #(CLK_HALF) i_clk = 1'b1;
        #(CLK_HALF) i_clk = 1'b0;
    end

    // Register copies and curve walk state of the model.
    logic [3:0]  order_reg   = 4'd0;
    logic [30:0] length_reg  = LENGTH_AFTER_RESET;
    logic [2:0]  heading_reg = 3'd0;
    logic [31:0] origin_x    = '0;
    logic [31:0] origin_y    = '0;

    logic [31:0] cur_x       = '0;
    logic [31:0] cur_y       = '0;
    logic [31:0] unit_len    = '0;
    logic [31:0] unit_rise   = '0;
    int unsigned seg_count   = 0;
    int unsigned live_order  = 0;
    logic [2:0]  live_heading = HEAD_E;
    logic        curve_live  = 1'b0;

    t_segment pending_segments[$];
    logic     typed_next = 1'b0;
    t_segment typed_seg  = NO_SEG;
    int       error_count  = 0;
    int       quiet_cycles = 0;
    bit       sender_steady = 1'b0;

    function automatic t_stim_row cfg_row(input logic [CFG_INDEX_W-1:0] index,
                                          input logic [CFG_DATA_W-1:0] data);
        return '{ROW_CFG, index, data, 1'b0, 1'b0, NO_SEG};
    endfunction

    function automatic t_stim_row item_row(input logic restart, input logic typed,
                                           input t_segment seg);
        return '{ROW_ITEM, CFG_CURVE_ORDER, 32'd0, restart, typed, seg};
    endfunction

    t_stim_row directed_rows [TABLE_ROWS] = '{
        item_row(1'b0, 1'b1, FIRST_SEG),
        item_row(1'b1, 1'b1, FIRST_SEG),
        item_row(1'b0, 1'b1, FIRST_SEG),
        cfg_row(CFG_CURVE_ORDER, 32'd1),
        cfg_row(CFG_BASE_LENGTH, 32'h7FFF_FFFF),
        cfg_row(CFG_START_DIRECTION, 32'd5),
        cfg_row(CFG_START_X, 32'h7FFF_FFFF),
        cfg_row(CFG_START_Y, 32'h8000_0000),
        item_row(1'b0, 1'b0, NO_SEG),
        item_row(1'b0, 1'b0, NO_SEG),
        item_row(1'b0, 1'b0, NO_SEG),
        item_row(1'b0, 1'b0, NO_SEG),
        item_row(1'b0, 1'b0, NO_SEG),
        item_row(1'b1, 1'b0, NO_SEG),
        cfg_row(CFG_CURVE_ORDER, 32'd15),
        cfg_row(CFG_BASE_LENGTH, 32'd0),
        cfg_row(CFG_START_DIRECTION, 32'd7),
        cfg_row(CFG_START_X, 32'd0),
        cfg_row(CFG_START_Y, 32'd0),
        item_row(1'b1, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, HEAD_NE, 1'b0}),
        item_row(1'b0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, HEAD_NW, 1'b0}),
        item_row(1'b0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, HEAD_E, 1'b0}),
        item_row(1'b0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, HEAD_NE, 1'b0}),
        cfg_row(CFG_CURVE_ORDER, 32'd1),
        cfg_row(CFG_BASE_LENGTH, 32'd5),
        cfg_row(CFG_START_DIRECTION, 32'd6),
        cfg_row(CFG_START_X, 32'hFFFF_FFFF),
        cfg_row(CFG_START_Y, 32'h7FFF_FFFF),
        item_row(1'b1, 1'b0, NO_SEG),
        item_row(1'b0, 1'b0, NO_SEG),
        item_row(1'b0, 1'b0, NO_SEG),
        item_row(1'b0, 1'b0, NO_SEG),
        item_row(1'b0, 1'b0, NO_SEG)
    };

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] index,
                                           input logic [CFG_DATA_W-1:0] data);
        case (index)
            CFG_CURVE_ORDER:     order_reg   = data[3:0];
            CFG_BASE_LENGTH:     length_reg  = data[30:0];
            CFG_START_DIRECTION: heading_reg = data[2:0];
            CFG_START_X:         origin_x    = data;
            CFG_START_Y:         origin_y    = data;
            default: ;
        endcase
    endfunction

    function automatic t_segment predict_segment(input logic restart_flag);
        t_segment    s;
        int unsigned divisor;
        int unsigned total;
        logic [2:0]  dir;
        logic [1:0]  digit;
        logic [31:0] half_len;
        logic [31:0] dx;
        logic [31:0] dy;
        if (restart_flag || !curve_live) begin
            live_order   = (order_reg > ORDER_CAP) ? ORDER_CAP : order_reg;
            live_heading = (heading_reg > HEAD_SE) ? heading_reg - 3'd6 : heading_reg;
            divisor = 1;
            for (int i = 0; i < live_order; i++) begin
                divisor = divisor * 3;
            end
            unit_len  = {1'b0, length_reg} / divisor;
            unit_rise = 32'((64'(unit_len) * SQRT3_OVER_2 + ROUND_UP) >> 32);
            cur_x      = origin_x;
            cur_y      = origin_y;
            seg_count  = 0;
            curve_live = 1'b1;
        end
        dir = live_heading;
        for (int i = 0; i < live_order; i++) begin
            digit = seg_count[2*i +: 2];
            if (digit == DIGIT_LEFT) begin
                dir = (dir == HEAD_SE) ? HEAD_E : dir + 3'd1;
            end else if (digit == DIGIT_RIGHT) begin
                dir = (dir == HEAD_E) ? HEAD_SE : dir - 3'd1;
            end
        end
        half_len = (unit_len + 32'd1) >> 1;
        case (dir)
            HEAD_E: begin
                dx = unit_len;
                dy = '0;
            end
            HEAD_NE: begin
                dx = half_len;
                dy = unit_rise;
            end
            HEAD_NW: begin
                dx = -half_len;
                dy = unit_rise;
            end
            HEAD_W: begin
                dx = -unit_len;
                dy = '0;
            end
            HEAD_SW: begin
                dx = -half_len;
                dy = -unit_rise;
            end
            default: begin
                dx = half_len;
                dy = -unit_rise;
            end
        endcase
        s.x0 = cur_x;
        s.y0 = cur_y;
        cur_x = cur_x + dx;
        cur_y = cur_y + dy;
        s.x1 = cur_x;
        s.y1 = cur_y;
        s.heading = dir;
        total = 32'd1 << (2 * live_order);
        s.last = (seg_count + 1 >= total);
        if (s.last) begin
            seg_count  = 0;
            curve_live = 1'b0;
        end else begin
            seg_count = seg_count + 1;
        end
        return s;
    endfunction

    function automatic int idle_cycles(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %08h, actual %08h", name, want, got);
            error_count++;
        end
    endtask

    // Transfer monitor: results are compared before the request of the same
    // edge is modelled, as a result always belongs to an earlier request.
    always @(posedge i_clk) begin
        t_segment want;
        logic     progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (seg_ch.valid && seg_ch.ready) begin
                progress = 1'b1;
                if (pending_segments.size() == 0) begin
                    $error("segment transfer with no request outstanding");
                    error_count++;
                end else begin
                    want = pending_segments.pop_front();
                    check_field("seg_x0", want.x0, seg_ch.seg_x0);
                    check_field("seg_y0", want.y0, seg_ch.seg_y0);
                    check_field("seg_x1", want.x1, seg_ch.seg_x1);
                    check_field("seg_y1", want.y1, seg_ch.seg_y1);
                    check_field("heading", 32'(want.heading), 32'(seg_ch.heading));
                    check_field("last_segment", 32'(want.last), 32'(seg_ch.last_segment));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                progress = 1'b1;
                want = predict_segment(req_ch.restart);
                if (typed_next) begin
                    want = typed_seg;
                end
                pending_segments.push_back(want);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                progress = 1'b1;
                apply_register(i_cfg_index, i_cfg_data);
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int burst;
        int stall;
        seg_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            seg_ch.ready = 1'b1;
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 12);
            repeat (burst) @(negedge i_clk);
            stall = idle_cycles(1'b0);
            if (stall > 0) begin
                seg_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
        end
    end

    task automatic push_request(input logic restart_flag, input logic typed,
                                input t_segment seg);
        int gap;
        gap = idle_cycles(sender_steady);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.restart = restart_flag;
        typed_next     = typed;
        typed_seg      = seg;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic settle();
        req_ch.valid = 1'b0;
        while (pending_segments.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int          random_count;
        int          phase_len;
        int          r;
        logic [31:0] value;
        logic        restart_flag;

        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_CURVE_ORDER;
        i_cfg_data     = '0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                settle();
                write_register(directed_rows[i].index, directed_rows[i].data);
            end else begin
                push_request(directed_rows[i].restart, directed_rows[i].typed,
                             directed_rows[i].seg);
            end
        end

        random_count = 0;
        while (random_count < RANDOM_ITEMS) begin
            settle();
            sender_steady = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            value = (r < 70) ? $urandom_range(0, 3)
                  : (r < 90) ? $urandom_range(4, 6) : $urandom_range(7, 15);
            write_register(CFG_CURVE_ORDER, value);
            case ($urandom_range(0, 4))
                0:       value = 32'd0;
                1:       value = 32'h7FFF_FFFF;
                2:       value = $urandom_range(0, 64);
                3:       value = $urandom >> $urandom_range(1, 31);
                default: value = $urandom;
            endcase
            write_register(CFG_BASE_LENGTH, value);
            write_register(CFG_START_DIRECTION, $urandom_range(0, 7));
            write_register(CFG_START_X, random_coord());
            write_register(CFG_START_Y, random_coord());
            phase_len = $urandom_range(20, 120);
            for (int k = 0; k < phase_len; k++) begin
                restart_flag = (k == 0) ? 1'($urandom_range(0, 1))
                                        : ($urandom_range(0, 24) == 0);
                if ($urandom_range(0, 59) == 0) begin
                    settle();
                end
                push_request(restart_flag, 1'b0, NO_SEG);
                random_count++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
